// ----- rtl/eflba_pkg.sv -----
// Shared types, widths and codes for the free-list block allocator.
package eflba_pkg;

  localparam int ACTION_W     = 3;
  localparam int OFFSET_W     = 24;
  localparam int STATUS_W     = 2;
  localparam int GRANT_W      = 20;
  localparam int LINK_W       = 8;
  localparam int BB_W         = 13;
  localparam int PROD_W       = LINK_W + BB_W;
  localparam int CFG_INDEX_W  = 1;
  localparam int CFG_DATA_W   = 13;

  localparam int MAX_BLOCKS_DEF = 255;
  localparam logic [BB_W-1:0] BB_MAX = BB_W'(4096);

  localparam logic [ACTION_W-1:0] ACT_ALLOC   = 3'd0;
  localparam logic [ACTION_W-1:0] ACT_FREE    = 3'd1;
  localparam logic [ACTION_W-1:0] ACT_INIT    = 3'd2;
  localparam logic [ACTION_W-1:0] ACT_RELEASE = 3'd3;
  localparam logic [ACTION_W-1:0] ACT_CHECK   = 3'd4;

  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_OUTSIDE  = 2'd2;

  localparam logic [CFG_INDEX_W-1:0] CFG_BLOCK_BYTES = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_BLOCK_COUNT = 1'd1;

  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic [OFFSET_W-1:0] block_offset;
  } cmd_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [GRANT_W-1:0]  granted_offset;
    logic [LINK_W-1:0]   blocks_free;
    logic                in_chunk;
  } result_t;

endpackage

// ----- rtl/embedded_free_list_block_allocator_top.sv -----
// Free-list block allocator: control, link memory, divider and result register.
//
// One command is worked at a time. A command transfer happens at a clock edge
// with start high and busy low; its result appears on result for exactly one
// cycle with done high, and busy drops in that same cycle, so the next command
// may be taken while done is shown. The receiver cannot stall results.
// What follows acceptance: release, check and unused actions, allocate on an
// empty list and free of an offset outside the chunk answer from the execute
// state; allocate adds one read of the link memory; free otherwise runs a
// bit-serial divider resolving one of the 24 offset bits per cycle, then
// pushes the block unless its index is out of range; init writes one link
// per cycle into the link memory, one for each block of the count. Block size
// and count come through the cfg channel, which is always ready; write it only
// while busy is low and no result is pending. The link memory needs no
// clearing pass after reset.
module embedded_free_list_block_allocator_top #(
  parameter int MAX_BLOCKS = eflba_pkg::MAX_BLOCKS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   start,
  output logic                                   busy,
  input  eflba_pkg::cmd_t                        cmd,
  output logic                                   done,
  output eflba_pkg::result_t                     result,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [eflba_pkg::CFG_INDEX_W-1:0]      cfg_index,
  input  logic [eflba_pkg::CFG_DATA_W-1:0]       cfg_data
);

  localparam int IDX_W = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int LW    = eflba_pkg::LINK_W;
  localparam int BW    = eflba_pkg::BB_W;
  localparam int OW    = eflba_pkg::OFFSET_W;
  localparam int PW    = eflba_pkg::PROD_W;
  localparam int CNT_W = $clog2(OW + 1);
  localparam logic [LW-1:0] MAX_LINK = LW'(MAX_BLOCKS);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_EXEC     = 3'd1;
  localparam logic [2:0] S_ALLOC_RD = 3'd2;
  localparam logic [2:0] S_DIV      = 3'd3;
  localparam logic [2:0] S_FREE_WR  = 3'd4;
  localparam logic [2:0] S_INIT     = 3'd5;

  // Configuration registers
  logic [BW-1:0] cfg_bb;
  logic [LW-1:0] cfg_cnt;

  // Allocator state
  logic [LW-1:0] free_head;
  logic [LW-1:0] free_count;
  logic          chunk_present;
  logic [LW-1:0] chunk_blocks;
  logic [PW-1:0] chunk_end;

  // Per-command working registers
  logic [2:0]           state;
  eflba_pkg::cmd_t      cmd_q;
  logic [BW-1:0]        bb;
  logic [LW-1:0]        n_blocks;
  logic [PW-1:0]        prod;
  logic [LW-1:0]        walk;
  logic [BW-1:0]        rem;
  logic [OW-1:0]        quot;
  logic [CNT_W-1:0]     div_cnt;

  // Link memory
  logic [LW-1:0]    link_mem [MAX_BLOCKS];
  logic             mem_we;
  logic [IDX_W-1:0] mem_wa;
  logic [LW-1:0]    mem_wd;
  logic [LW-1:0]    mem_rd;

  logic [BW-1:0]  bb_eff;
  logic [LW-1:0]  cnt_eff;
  logic [LW-1:0]  mult_a;
  logic           in_range;
  logic [BW+1:0]  trial;
  logic           idx_bad;

  assign cfg_ready = 1'b1;

  // Clamp block size to 1..4096 and count to the link memory depth.
  always_comb begin
    if (cfg_bb == '0) begin
      bb_eff = BW'(1);
    end else if (cfg_bb > eflba_pkg::BB_MAX) begin
      bb_eff = eflba_pkg::BB_MAX;
    end else begin
      bb_eff = cfg_bb;
    end
    cnt_eff = (cfg_cnt > MAX_LINK) ? MAX_LINK : cfg_cnt;
    mult_a  = (cmd.action == eflba_pkg::ACT_INIT) ? cnt_eff : free_head;
  end

  always_comb begin
    in_range = chunk_present && (cmd_q.block_offset < OW'(chunk_end));
    trial    = {1'b0, rem, quot[OW-1]} - {2'b00, bb};
    idx_bad  = (quot >= OW'(chunk_blocks)) || (quot >= OW'(MAX_BLOCKS));
  end

  // Memory write port: init walk or free push.
  always_comb begin
    mem_we = 1'b0;
    mem_wa = walk[IDX_W-1:0];
    mem_wd = walk + LW'(1);
    if (state == S_INIT) begin
      mem_we = 1'b1;
    end else if (state == S_FREE_WR && !idx_bad) begin
      mem_we = 1'b1;
      mem_wa = quot[IDX_W-1:0];
      mem_wd = free_head;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      link_mem[mem_wa] <= mem_wd;
    end
    mem_rd <= link_mem[free_head[IDX_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_bb <= BW'(1);
      cfg_cnt <= LW'(255);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        eflba_pkg::CFG_BLOCK_BYTES: cfg_bb  <= cfg_data[BW-1:0];
        eflba_pkg::CFG_BLOCK_COUNT: cfg_cnt <= cfg_data[LW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      busy          <= 1'b0;
      done          <= 1'b0;
      free_head     <= '0;
      free_count    <= '0;
      chunk_present <= 1'b0;
      chunk_blocks  <= '0;
      chunk_end     <= '0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          // Latch the command and run the shared multiply for alloc or init.
          if (start && !busy) begin
            cmd_q    <= cmd;
            bb       <= bb_eff;
            n_blocks <= cnt_eff;
            prod     <= PW'(mult_a) * PW'(bb_eff);
            busy     <= 1'b1;
            state    <= S_EXEC;
          end
        end
        S_EXEC: begin
          result.status         <= eflba_pkg::ST_OK;
          result.granted_offset <= '0;
          result.blocks_free    <= free_count;
          result.in_chunk       <= 1'b0;
          case (cmd_q.action)
            eflba_pkg::ACT_ALLOC: begin
              if (free_count == '0) begin
                result.status <= eflba_pkg::ST_EMPTY;
                done          <= 1'b1;
                busy          <= 1'b0;
                state         <= S_IDLE;
              end else begin
                state <= S_ALLOC_RD;
              end
            end
            eflba_pkg::ACT_FREE: begin
              if (!in_range) begin
                result.status <= eflba_pkg::ST_OUTSIDE;
                done          <= 1'b1;
                busy          <= 1'b0;
                state         <= S_IDLE;
              end else begin
                rem     <= '0;
                quot    <= cmd_q.block_offset;
                div_cnt <= CNT_W'(OW);
                state   <= S_DIV;
              end
            end
            eflba_pkg::ACT_INIT: begin
              chunk_end <= prod;
              walk      <= '0;
              if (n_blocks == '0) begin
                chunk_blocks       <= '0;
                free_head          <= '0;
                free_count         <= '0;
                chunk_present      <= 1'b1;
                result.blocks_free <= '0;
                done               <= 1'b1;
                busy               <= 1'b0;
                state              <= S_IDLE;
              end else begin
                state <= S_INIT;
              end
            end
            eflba_pkg::ACT_RELEASE: begin
              chunk_present      <= 1'b0;
              chunk_blocks       <= '0;
              chunk_end          <= '0;
              free_head          <= '0;
              free_count         <= '0;
              result.blocks_free <= '0;
              done               <= 1'b1;
              busy               <= 1'b0;
              state              <= S_IDLE;
            end
            eflba_pkg::ACT_CHECK: begin
              result.in_chunk <= in_range;
              result.status   <= in_range ? eflba_pkg::ST_OK : eflba_pkg::ST_OUTSIDE;
              done            <= 1'b1;
              busy            <= 1'b0;
              state           <= S_IDLE;
            end
            default: begin
              done  <= 1'b1;
              busy  <= 1'b0;
              state <= S_IDLE;
            end
          endcase
        end
        S_ALLOC_RD: begin
          // Link of the popped head is on the memory output now.
          free_head             <= (free_head < MAX_LINK) ? mem_rd : '0;
          free_count            <= free_count - LW'(1);
          result.granted_offset <= prod[eflba_pkg::GRANT_W-1:0];
          result.blocks_free    <= free_count - LW'(1);
          done                  <= 1'b1;
          busy                  <= 1'b0;
          state                 <= S_IDLE;
        end
        S_DIV: begin
          // Restoring division, one quotient bit per cycle.
          if (!trial[BW+1]) begin
            rem  <= trial[BW-1:0];
            quot <= {quot[OW-2:0], 1'b1};
          end else begin
            rem  <= {rem[BW-2:0], quot[OW-1]};
            quot <= {quot[OW-2:0], 1'b0};
          end
          div_cnt <= div_cnt - CNT_W'(1);
          if (div_cnt == CNT_W'(1)) begin
            state <= S_FREE_WR;
          end
        end
        S_FREE_WR: begin
          result.in_chunk <= 1'b1;
          if (idx_bad) begin
            result.status <= eflba_pkg::ST_OUTSIDE;
          end else begin
            free_head          <= quot[LW-1:0];
            free_count         <= free_count + LW'(1);
            result.blocks_free <= free_count + LW'(1);
          end
          done  <= 1'b1;
          busy  <= 1'b0;
          state <= S_IDLE;
        end
        S_INIT: begin
          // Chain entry walk -> walk + 1, one link per cycle.
          walk <= walk + LW'(1);
          if (walk == n_blocks - LW'(1)) begin
            chunk_blocks       <= n_blocks;
            free_head          <= '0;
            free_count         <= n_blocks;
            chunk_present      <= 1'b1;
            result.blocks_free <= n_blocks;
            done               <= 1'b1;
            busy               <= 1'b0;
            state              <= S_IDLE;
          end
        end
        default: begin
          busy  <= 1'b0;
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTH
  a_idle_busy: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) == !busy)
    else $error("busy disagrees with controller state");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("accepted command did not raise busy");

  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("two results in consecutive cycles");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    done |-> (result.status == eflba_pkg::ST_OK || result.status == eflba_pkg::ST_EMPTY ||
              result.status == eflba_pkg::ST_OUTSIDE))
    else $error("undefined status code");
`endif

endmodule

// ----- tb/tb.sv -----
// Self-checking testbench for the free-list block allocator.
`timescale 1ns / 1ps

import eflba_pkg::*;

// Shadow of the allocator: tracks links, head, free count and chunk extent, and
// queues the answer each accepted command should produce.
class free_list_shadow;
  localparam int MAX_REPORTED = 50;

  logic [LINK_W-1:0] links [MAX_BLOCKS_DEF];
  logic [LINK_W-1:0] head;
  logic [LINK_W-1:0] count;
  bit                present;
  int unsigned       chunk_blocks;
  int unsigned       chunk_end;
  logic [BB_W-1:0]   reg_bytes;
  logic [LINK_W-1:0] reg_count;
  result_t           answers_due [$];
  int unsigned       live_offsets [$];
  int                mismatches;

  function new();
    foreach (links[i]) links[i] = '0;
    head         = '0;
    count        = '0;
    present      = 1'b0;
    chunk_blocks = 0;
    chunk_end    = 0;
    reg_bytes    = BB_W'(1);
    reg_count    = LINK_W'(MAX_BLOCKS_DEF);
    mismatches   = 0;
  endfunction

  // Zero and oversize block sizes are clamped.
  function int unsigned eff_bytes();
    if (reg_bytes == '0) return 1;
    if (reg_bytes > BB_MAX) return BB_MAX;
    return reg_bytes;
  endfunction

  function void set_register(logic [CFG_INDEX_W-1:0] index, logic [CFG_DATA_W-1:0] value);
    if (index == CFG_BLOCK_BYTES) reg_bytes = value;
    else if (index == CFG_BLOCK_COUNT) reg_count = value[LINK_W-1:0];
  endfunction

  function void note_command(cmd_t c);
    result_t     r;
    int unsigned bb, off, idx, n, grant;
    r   = '0;
    bb  = eff_bytes();
    off = c.block_offset;
    case (c.action)
      ACT_ALLOC: begin
        if (count == '0) begin
          r.status = ST_EMPTY;
        end else begin
          grant = head * bb;
          r.granted_offset = GRANT_W'(grant);
          live_offsets.push_back(grant);
          head  = (head < MAX_BLOCKS_DEF) ? links[head] : '0;
          count = count - 1'b1;
        end
      end
      ACT_FREE: begin
        r.in_chunk = present && (off < chunk_end);
        idx = off / bb;
        if (!r.in_chunk || idx >= chunk_blocks || idx >= MAX_BLOCKS_DEF) begin
          r.status = ST_OUTSIDE;
        end else begin
          links[idx] = head;
          head  = LINK_W'(idx);
          count = count + 1'b1;
        end
      end
      ACT_INIT: begin
        n = (reg_count > MAX_BLOCKS_DEF) ? MAX_BLOCKS_DEF : reg_count;
        for (int i = 0; i < n; i++) links[i] = LINK_W'(i + 1);
        chunk_blocks = n;
        chunk_end    = n * bb;
        head         = '0;
        count        = LINK_W'(n);
        present      = 1'b1;
        live_offsets.delete();
      end
      ACT_RELEASE: begin
        present      = 1'b0;
        chunk_blocks = 0;
        chunk_end    = 0;
        head         = '0;
        count        = '0;
        live_offsets.delete();
      end
      ACT_CHECK: begin
        r.in_chunk = present && (off < chunk_end);
        r.status   = r.in_chunk ? ST_OK : ST_OUTSIDE;
      end
      default: ;
    endcase
    r.blocks_free = count;
    answers_due.push_back(r);
  endfunction

  task report_mismatch(string msg);
    if (mismatches < MAX_REPORTED) $display("MISMATCH at %0t ns: %s", $time, msg);
    mismatches++;
  endtask

  task check_result(result_t got);
    result_t want;
    if (answers_due.size() == 0) begin
      report_mismatch($sformatf("unexpected result %p", got));
      return;
    end
    want = answers_due.pop_front();
    if (got.status !== want.status)
      report_mismatch($sformatf("status %0d, want %0d", got.status, want.status));
    if (got.granted_offset !== want.granted_offset)
      report_mismatch($sformatf("granted_offset %0d, want %0d",
                                got.granted_offset, want.granted_offset));
    if (got.blocks_free !== want.blocks_free)
      report_mismatch($sformatf("blocks_free %0d, want %0d",
                                got.blocks_free, want.blocks_free));
    if (got.in_chunk !== want.in_chunk)
      report_mismatch($sformatf("in_chunk %0d, want %0d", got.in_chunk, want.in_chunk));
  endtask
endclass

module tb;
  localparam int WATCHDOG_LIMIT = 3000;  // long enough to cover an init of 255 blocks
  localparam int SETTLE_CYCLES  = 4;
  localparam int TAIL_CYCLES    = 40;
  localparam int RANDOM_ITEMS   = 1700;

  // Action codes past check do nothing and answer ok.
  localparam logic [ACTION_W-1:0] ACT_SPARE_LO = 3'd5;
  localparam logic [ACTION_W-1:0] ACT_SPARE_HI = 3'd7;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   start = 1'b0;
  logic                   busy;
  cmd_t                   cmd = '0;
  logic                   done;
  result_t                result;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  free_list_shadow sb = new();
  int              stall_cycles = 0;

  always #6 clk = ~clk;

  embedded_free_list_block_allocator_top dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .cmd       (cmd),
    .done      (done),
    .result    (result),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Observe every transfer at the rising edge. Inputs only move on the falling
  // edge, so the values seen here are the ones the block registers. A command
  // accepted at the same edge as an older result is appended behind it, so the
  // order of the two calls does not matter.
  always @(posedge clk) begin
    bit moved;
    if (!rst) begin
      moved = 1'b0;
      if (start && !busy) begin
        sb.note_command(cmd);
        moved = 1'b1;
      end
      if (done) begin
        sb.check_result(result);
        moved = 1'b1;
      end
      if (cfg_valid && cfg_ready) begin
        sb.set_register(cfg_index, cfg_data);
        moved = 1'b1;
      end
      // Watchdog: give up after a long run of cycles with no transfer at all.
      stall_cycles = moved ? 0 : stall_cycles + 1;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  // Present one command and hold it until the block takes it. Called and
  // returns on a falling edge; start stays high so a burst can continue.
  task automatic send(input logic [ACTION_W-1:0] action, input logic [OFFSET_W-1:0] offset);
    start = 1'b1;
    cmd.action = action;
    cmd.block_offset = offset;
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
  endtask

  // Stop sending and wait until every outstanding answer has come back, then
  // let the block settle before anything else happens.
  task automatic drain();
    start = 1'b0;
    while (sb.answers_due.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Write block size then block count, holding valid across both transfers.
  task automatic write_registers(input logic [CFG_DATA_W-1:0] bytes_value,
                                 input logic [CFG_DATA_W-1:0] count_value);
    cfg_valid = 1'b1;
    cfg_index = CFG_BLOCK_BYTES;
    cfg_data  = bytes_value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_index = CFG_BLOCK_COUNT;
    cfg_data  = count_value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Offsets that hit the interesting spots: both ends of the chunk, just past
  // it, inside it, and anywhere in the 24-bit range.
  function automatic logic [OFFSET_W-1:0] pick_offset();
    int unsigned top;
    top = sb.chunk_end;
    case ($urandom_range(0, 6))
      0: return OFFSET_W'($urandom());
      1: return '0;
      2: return OFFSET_W'(top);
      3: return OFFSET_W'((top > 0) ? top - 1 : 0);
      4: return OFFSET_W'(top + $urandom_range(1, 64));
      default: return OFFSET_W'((top > 0) ? $urandom_range(0, top - 1) : $urandom_range(0, 15));
    endcase
  endfunction

  // Mostly allocate/free traffic that returns blocks handed out earlier, mixed
  // with checks, occasional rebuilds and releases, and some noise.
  function automatic cmd_t pick_command();
    cmd_t        c;
    int unsigned roll, k, bb;
    roll = $urandom_range(0, 99);
    bb   = sb.eff_bytes();
    c.action       = ACT_ALLOC;
    c.block_offset = pick_offset();
    if (roll < 40) begin
      c.action = ACT_ALLOC;
    end else if (roll < 70) begin
      c.action = ACT_FREE;
      // Return a live block most of the time, sometimes misaligned within it.
      if (sb.live_offsets.size() > 0 && $urandom_range(0, 9) < 8) begin
        k = $urandom_range(0, sb.live_offsets.size() - 1);
        c.block_offset = OFFSET_W'(sb.live_offsets[k]);
        if ($urandom_range(0, 3) == 0) c.block_offset += OFFSET_W'($urandom_range(0, bb - 1));
        sb.live_offsets.delete(k);
      end
    end else if (roll < 84) begin
      c.action = ACT_CHECK;
    end else if (roll < 88) begin
      c.action = ACT_INIT;
    end else if (roll < 90) begin
      c.action = ACT_RELEASE;
    end else if (roll < 93) begin
      c.action = ACTION_W'($urandom_range(ACT_SPARE_LO, ACT_SPARE_HI));
    end
    return c;
  endfunction

  // Block sizes: mostly small, with zero, the maximum and oversize values.
  function automatic logic [CFG_DATA_W-1:0] pick_bytes();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return CFG_DATA_W'(BB_MAX);
      2: return CFG_DATA_W'($urandom_range(BB_MAX + 1, (1 << CFG_DATA_W) - 1));
      3: return CFG_DATA_W'($urandom_range(1, BB_MAX));
      default: return CFG_DATA_W'($urandom_range(1, 64));
    endcase
  endfunction

  // Block counts: mostly small chunks, sometimes empty, full, or with the
  // upper data bits set (only the low byte is kept).
  function automatic logic [CFG_DATA_W-1:0] pick_count();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return CFG_DATA_W'(MAX_BLOCKS_DEF);
      2: return CFG_DATA_W'($urandom_range(256, (1 << CFG_DATA_W) - 1));
      default: return CFG_DATA_W'($urandom_range(1, 24));
    endcase
  endfunction

  initial begin
    int unsigned sent, phase_len, burst_left;
    bit          bursty;
    cmd_t        next;

    repeat (9) @(negedge clk);
    rst = 1'b0;

    // Directed: no chunk yet, so nothing can read a link.
    send(ACT_ALLOC, '0);                // empty list
    send(ACT_FREE, '0);                 // free with no chunk
    send(ACT_CHECK, '1);                // check with no chunk
    send(ACT_RELEASE, '0);              // release while absent
    for (int a = ACT_SPARE_LO; a <= ACT_SPARE_HI; a++) send(ACTION_W'(a), '1);

    // First init runs with the reset count of 255, so every link gets written.
    send(ACT_INIT, '0);
    send(ACT_CHECK, OFFSET_W'(MAX_BLOCKS_DEF - 1));  // last byte of the chunk
    send(ACT_CHECK, OFFSET_W'(MAX_BLOCKS_DEF));      // the chunk end itself
    send(ACT_ALLOC, '0);
    send(ACT_ALLOC, '0);
    send(ACT_FREE, '0);
    send(ACT_FREE, '0);                 // double free goes unnoticed
    send(ACT_FREE, '1);                 // far outside
    send(ACT_ALLOC, '0);

    // Largest block, single-block chunk.
    drain();
    write_registers(CFG_DATA_W'(BB_MAX), CFG_DATA_W'(1));
    send(ACT_INIT, '0);
    send(ACT_ALLOC, '0);
    send(ACT_ALLOC, '0);                // list now empty
    send(ACT_FREE, OFFSET_W'(BB_MAX - 1));  // misaligned, same block
    send(ACT_FREE, OFFSET_W'(BB_MAX));      // past the end
    send(ACT_CHECK, OFFSET_W'(BB_MAX - 1));

    // Zero size clamps to one; zero count gives a present but empty chunk.
    drain();
    write_registers('0, '0);
    send(ACT_INIT, '0);
    send(ACT_CHECK, '0);
    send(ACT_FREE, '0);
    send(ACT_ALLOC, '0);

    // Random phases. Each one drains, rewrites both registers while idle and
    // usually rebuilds the chunk; skipping the rebuild leaves the old extent
    // latched while the new block size is used.
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      drain();
      write_registers(pick_bytes(), pick_count());
      if ($urandom_range(0, 4) != 0) begin
        send(ACT_INIT, OFFSET_W'($urandom()));
        sent++;
      end
      phase_len  = $urandom_range(40, 120);
      bursty     = ($urandom_range(0, 2) != 0);
      burst_left = $urandom_range(1, 16);
      for (int i = 0; i < phase_len; i++) begin
        next = pick_command();
        send(next.action, next.block_offset);
        if (next.action < ACT_SPARE_LO) sent++;
        if (bursty && --burst_left == 0) begin
          // Drop start for a random gap, then begin a new burst.
          start = 1'b0;
          repeat ($urandom_range(1, 8)) @(negedge clk);
          burst_left = $urandom_range(1, 16);
        end
        if ($urandom_range(0, 149) == 0) drain();
      end
    end

    // Wait out every outstanding answer, then a quiet tail for strays.
    drain();
    repeat (TAIL_CYCLES) @(negedge clk);
    if (sb.mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule
